[rtl/core/utrb_pkg.sv]
// utrb_pkg: shared types and constants for the serial port ring buffer unit
// no dependencies; used by every module of the unit except utrb_ram, by scoped name

package utrb_pkg;

  // event codes carried in req_type
  localparam logic [1:0] REQ_RX_BYTE  = 2'd0;
  localparam logic [1:0] REQ_HOST_WR  = 2'd1;
  localparam logic [1:0] REQ_HOST_RD  = 2'd2;
  localparam logic [1:0] REQ_TX_READY = 2'd3;

  // one input transaction
  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] byte_in;
    logic       rx_error;
  } req_t;

  // one result transaction
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       accepted;
    logic       rx_pending;
    logic       tx_idle;
  } rsp_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

[rtl/core/uart_tx_rx_ring_buffers_unit.sv]
// uart_tx_rx_ring_buffers_unit: transmit and receive ring buffers of a serial port
// sequence: a taken transaction passes ST_EXEC; result strobe done rises in ST_DONE
// steps: capture, buffer access, result, with no new transaction taken meanwhile;
//   the registered read port of each buffer ram sets the middle step
// reset: synchronous active high rst empties both buffers; ram contents stay undefined
// the receiver cannot stall: each result is flagged by done for exactly one cycle

module uart_tx_rx_ring_buffers_unit #(
  parameter int TX_DEPTH = 32,
  parameter int RX_DEPTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  utrb_pkg::req_t req,
  output logic           done,
  output utrb_pkg::rsp_t rsp
);

  utrb_pkg::cmd_t cmd;

  // sequencing
  utrb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // buffers and pointers
  utrb_dpath #(
    .TX_DEPTH (TX_DEPTH),
    .RX_DEPTH (RX_DEPTH)
  ) u_dpath (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

endmodule

[rtl/core/utrb_ram.sv]
// utrb_ram: generic single write port, single read port ram with registered read
// no dependencies

module utrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/utrb_ctrl.sv]
// utrb_ctrl: controller state machine sequencing one transaction at a time
// depends on utrb_pkg

module utrb_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  output logic            done,
  output utrb_pkg::cmd_t  cmd
);

  utrb_pkg::state_t state;
  utrb_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= utrb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.exec   = 1'b0;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      utrb_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = utrb_pkg::ST_EXEC;
        end
      end
      utrb_pkg::ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = utrb_pkg::ST_DONE;
      end
      utrb_pkg::ST_DONE: begin
        done       = 1'b1;
        state_next = utrb_pkg::ST_IDLE;
      end
      default: begin
        state_next = utrb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/utrb_dpath.sv]
// utrb_dpath: ring buffer pointers, flags and the two buffer rams
// depends on utrb_pkg and utrb_ram

module utrb_dpath #(
  parameter int TX_DEPTH = 32,
  parameter int RX_DEPTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  utrb_pkg::cmd_t cmd,
  input  utrb_pkg::req_t req,
  output utrb_pkg::rsp_t rsp
);

  localparam int TX_AW = $clog2(TX_DEPTH);
  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);
  localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);

  utrb_pkg::req_t   req_q;
  logic [TX_AW-1:0] tx_rp, tx_rp_next, tx_wp, tx_wp_next, tx_rp_inc, tx_wp_inc;
  logic [RX_AW-1:0] rx_rp, rx_rp_next, rx_wp, rx_wp_next, rx_rp_inc, rx_wp_inc;
  logic             rx_has_data, rx_has_data_next;
  logic             tx_empty, tx_empty_next;
  logic             txv, txv_next, rxv, rxv_next, acc, acc_next;
  logic             tx_full;
  logic             tx_we, rx_we;
  logic [7:0]       tx_rdata, rx_rdata;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
    end
  end

  // wrapping pointer increments
  assign tx_rp_inc = (tx_rp == TX_LAST) ? '0 : tx_rp + 1'b1;
  assign tx_wp_inc = (tx_wp == TX_LAST) ? '0 : tx_wp + 1'b1;
  assign rx_rp_inc = (rx_rp == RX_LAST) ? '0 : rx_rp + 1'b1;
  assign rx_wp_inc = (rx_wp == RX_LAST) ? '0 : rx_wp + 1'b1;

  assign tx_full = (tx_wp == tx_rp) && !tx_empty;

  // event decode and state update
  always_comb begin
    tx_rp_next       = tx_rp;
    tx_wp_next       = tx_wp;
    rx_rp_next       = rx_rp;
    rx_wp_next       = rx_wp;
    rx_has_data_next = rx_has_data;
    tx_empty_next    = tx_empty;
    txv_next         = txv;
    rxv_next         = rxv;
    acc_next         = acc;
    tx_we            = 1'b0;
    rx_we            = 1'b0;
    if (cmd.exec) begin
      txv_next = 1'b0;
      rxv_next = 1'b0;
      acc_next = 1'b0;
      case (req_q.req_type)
        utrb_pkg::REQ_RX_BYTE: begin
          if (!req_q.rx_error) begin
            rx_we            = 1'b1;
            rx_wp_next       = rx_wp_inc;
            rx_has_data_next = 1'b1;
          end
        end
        utrb_pkg::REQ_HOST_WR: begin
          if (!tx_full) begin
            tx_we         = 1'b1;
            tx_wp_next    = tx_wp_inc;
            tx_empty_next = 1'b0;
            acc_next      = 1'b1;
          end
        end
        utrb_pkg::REQ_HOST_RD: begin
          if (rx_has_data) begin
            rxv_next   = 1'b1;
            rx_rp_next = rx_rp_inc;
            if (rx_rp_inc == rx_wp) begin
              rx_has_data_next = 1'b0;
            end
          end
        end
        utrb_pkg::REQ_TX_READY: begin
          if (!tx_empty) begin
            txv_next   = 1'b1;
            tx_rp_next = tx_rp_inc;
            if (tx_rp_inc == tx_wp) begin
              tx_empty_next = 1'b1;
            end
          end
        end
        default: begin
          txv_next = 1'b0;
        end
      endcase
    end
  end

  // pointer, flag and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_rp       <= '0;
      tx_wp       <= '0;
      rx_rp       <= '0;
      rx_wp       <= '0;
      rx_has_data <= 1'b0;
      tx_empty    <= 1'b1;
      txv         <= 1'b0;
      rxv         <= 1'b0;
      acc         <= 1'b0;
    end else begin
      tx_rp       <= tx_rp_next;
      tx_wp       <= tx_wp_next;
      rx_rp       <= rx_rp_next;
      rx_wp       <= rx_wp_next;
      rx_has_data <= rx_has_data_next;
      tx_empty    <= tx_empty_next;
      txv         <= txv_next;
      rxv         <= rxv_next;
      acc         <= acc_next;
    end
  end

  // transmit buffer, read at the read pointer every cycle
  utrb_ram #(
    .WIDTH (8),
    .DEPTH (TX_DEPTH)
  ) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_wp),
    .wdata (req_q.byte_in),
    .raddr (tx_rp),
    .rdata (tx_rdata)
  );

  // receive buffer
  utrb_ram #(
    .WIDTH (8),
    .DEPTH (RX_DEPTH)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_wp),
    .wdata (req_q.byte_in),
    .raddr (rx_rp),
    .rdata (rx_rdata)
  );

  // result fields, bytes forced to zero when not valid
  assign rsp.tx_valid   = txv;
  assign rsp.tx_byte    = txv ? tx_rdata : 8'd0;
  assign rsp.rx_valid   = rxv;
  assign rsp.rx_byte    = rxv ? rx_rdata : 8'd0;
  assign rsp.accepted   = acc;
  assign rsp.rx_pending = rx_has_data;
  assign rsp.tx_idle    = tx_empty;

endmodule

[rtl/core/utrb_checker.sv]
// utrb_checker: port level assertions for the ring buffer unit, bound to the top level
// depends on utrb_pkg

module utrb_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input utrb_pkg::req_t req,
  input logic           done,
  input utrb_pkg::rsp_t rsp
);

  // a taken transaction is followed by its result strobe done
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##2 done)
    else $error("result strobe missing after transaction");

  // no result without a transaction in flight
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe while idle");

  // one event never both sends and returns a byte
  a_one_action: assert property (@(posedge clk) disable iff (rst)
    done |-> !(rsp.tx_valid && rsp.rx_valid))
    else $error("transmit and receive byte in one result");

  // an accepted host write leaves the transmit buffer non-empty
  a_acc_not_idle: assert property (@(posedge clk) disable iff (rst)
    done && rsp.accepted |-> !rsp.tx_idle)
    else $error("accepted write but transmit buffer reports idle");

  // a returned byte only for a host read
  a_rx_kind: assert property (@(posedge clk) disable iff (rst)
    done && rsp.rx_valid |-> $past(req.req_type, 2) == utrb_pkg::REQ_HOST_RD)
    else $error("receive byte returned for a non-read transaction");

endmodule

bind uart_tx_rx_ring_buffers_unit utrb_checker u_utrb_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .req   (req),
  .done  (done),
  .rsp   (rsp)
);
